// ===== src/pngenc_pkg.sv =====
// shared types, constants and a crc function for the grayscale png encoder
`default_nettype none

package pngenc_pkg;

    localparam int MAX_DIM      = 16384;
    localparam int DIM_W        = 15;
    localparam int STORED_BLOCK = 65535;
    localparam int ADLER_MOD    = 65521;
    localparam int RAW_W        = 29;
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_AW       = $clog2(CMD_DEPTH);

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic pre;
        logic filt;
        logic pix;
        logic trail;
    } pend_t;

    typedef struct packed {
        pend_t      flags;
        logic [7:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } dims_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/pngenc_front.sv =====
// front end: accepts pixels, tracks raster position and queues byte commands
`default_nettype none

module pngenc_front
    import pngenc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_addr,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             fifo_full,
    output logic                  push,
    output cmd_t                  push_cmd,
    output dims_t                 dims
);

    logic [DIM_W-1:0] width_reg, width_next;
    logic [DIM_W-1:0] height_reg, height_next;
    dims_t            lat_reg, lat_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic             started_reg, started_next;
    logic             finished_reg, finished_next;
    logic             drain_reg, drain_next;
    logic [DIM_W-1:0] w_clamp, h_clamp, w_eff, h_eff;
    logic             acc, last_px;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return v;
    endfunction

    assign s_tready = !fifo_full;
    assign acc      = s_tvalid && s_tready;
    assign w_clamp  = clamp_dim(width_reg);
    assign h_clamp  = clamp_dim(height_reg);
    assign w_eff    = started_reg ? lat_reg.width  : w_clamp;
    assign h_eff    = started_reg ? lat_reg.height : h_clamp;
    assign last_px  = (col_reg == w_eff - DIM_W'(1)) && (row_reg == h_eff - DIM_W'(1));
    assign dims     = lat_reg;

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        lat_next      = lat_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        started_next  = started_reg;
        finished_next = finished_reg;
        drain_next    = drain_reg;
        push          = 1'b0;
        push_cmd      = '0;
        if (cfg_we) begin
            case (cfg_addr)
                REG_WIDTH:  width_next  = cfg_wdata;
                REG_HEIGHT: height_next = cfg_wdata;
                default: ;
            endcase
        end
        if (acc) begin
            if (!finished_reg) begin
                push                 = 1'b1;
                push_cmd.pixel       = s_tdata;
                push_cmd.flags.pre   = !started_reg;
                push_cmd.flags.filt  = (col_reg == '0);
                push_cmd.flags.pix   = 1'b1;
                push_cmd.flags.trail = last_px && started_reg;
                if (!started_reg) begin
                    started_next = 1'b1;
                    lat_next     = '{width: w_clamp, height: h_clamp};
                end
                if (col_reg == w_eff - DIM_W'(1)) begin
                    col_next = '0;
                    row_next = row_reg + DIM_W'(1);
                end else begin
                    col_next = col_reg + DIM_W'(1);
                end
                if (last_px) begin
                    finished_next = 1'b1;
                    drain_next    = !started_reg;
                end
            end else if (drain_reg) begin
                push                 = 1'b1;
                push_cmd.flags.trail = 1'b1;
                drain_next           = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= DIM_W'(1);
            height_reg   <= DIM_W'(1);
            lat_reg      <= '{width: DIM_W'(1), height: DIM_W'(1)};
            col_reg      <= '0;
            row_reg      <= '0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            drain_reg    <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            lat_reg      <= lat_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            started_reg  <= started_next;
            finished_reg <= finished_next;
            drain_reg    <= drain_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pngenc_cmd_fifo.sv =====
// small command queue between front and back
`default_nettype none

module pngenc_cmd_fifo
    import pngenc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  cmd_t      push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      pop_cmd,
    output logic      not_empty
);

    cmd_t            mem_reg [CMD_DEPTH];
    logic [CMD_AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CMD_AW:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == (CMD_AW+1)'(CMD_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_cmd   = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push && !full) begin
            wr_next = wr_reg + CMD_AW'(1);
        end
        if (pop && not_empty) begin
            rd_next = rd_reg + CMD_AW'(1);
        end
        cnt_next = cnt_reg + (CMD_AW+1)'(push && !full) - (CMD_AW+1)'(pop && not_empty);
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/pngenc_back.sv =====
// back end: byte sequencer with crc-32, adler-32 and stored block framing
`default_nettype none

module pngenc_back
    import pngenc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  dims_t      dims,
    input  wire logic  cmd_valid,
    input  cmd_t       cmd,
    output logic       pop,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRE   = 3'd1;
    localparam logic [2:0] ST_RAW   = 3'd2;
    localparam logic [2:0] ST_HDR   = 3'd3;
    localparam logic [2:0] ST_TRAIL = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [5:0]       idx_reg, idx_next;
    pend_t            pend_reg, pend_next;
    logic [7:0]       pix_reg, pix_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      alo_reg, alo_next, ahi_reg, ahi_next;
    logic [RAW_W-1:0] rawl_reg, rawl_next;
    logic [15:0]      blk_reg, blk_next;
    logic [15:0]      blen_reg, blen_next;
    logic             final_reg, final_next;
    logic [31:0]      zlen_reg, zlen_next;
    logic             mv_reg, mv_next;
    logic [7:0]       md_reg, md_next;
    logic             ml_reg, ml_next, mu_reg, mu_next;

    logic        adv, emit, e_last, e_end, crc_upd, crc_rst;
    logic [7:0]  ebyte;
    logic [15:0] w16;
    logic [30:0] prod;
    logic [12:0] za, zq, zblocks;
    logic [16:0] zs, zr;
    logic        zge;
    logic [16:0] lo_sum, hi_sum;
    logic [15:0] lo_n, hi_n;
    logic [31:0] crc_out;

    function automatic logic [2:0] first_state(input pend_t p);
        if (p.pre) begin
            return ST_PRE;
        end else if (p.filt || p.pix) begin
            return ST_RAW;
        end else if (p.trail) begin
            return ST_TRAIL;
        end
        return ST_IDLE;
    endfunction

    assign adv     = !mv_reg || m_tready;
    assign crc_out = ~crc_reg;
    assign w16     = {1'b0, dims.width} + 16'd1;
    assign prod    = 31'(w16) * 31'(dims.height);

    assign za      = rawl_reg[RAW_W-1:16];
    assign zs      = 17'(za) + 17'(rawl_reg[15:0]);
    assign zge     = zs >= 17'(STORED_BLOCK);
    assign zr      = zge ? zs - 17'(STORED_BLOCK) : zs;
    assign zq      = za + 13'(zge);
    assign zblocks = zq + 13'(zr != '0);

    assign lo_sum  = 17'(alo_reg) + 17'(ebyte);
    assign lo_n    = (lo_sum >= 17'(ADLER_MOD)) ? 16'(lo_sum - 17'(ADLER_MOD)) : lo_sum[15:0];
    assign hi_sum  = 17'(ahi_reg) + 17'(lo_n);
    assign hi_n    = (hi_sum >= 17'(ADLER_MOD)) ? 16'(hi_sum - 17'(ADLER_MOD)) : hi_sum[15:0];

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        pix_next   = pix_reg;
        alo_next   = alo_reg;
        ahi_next   = ahi_reg;
        rawl_next  = rawl_reg;
        blk_next   = blk_reg;
        blen_next  = blen_reg;
        final_next = final_reg;
        zlen_next  = zlen_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        e_last     = 1'b0;
        e_end      = 1'b0;
        crc_upd    = 1'b0;
        crc_rst    = 1'b0;
        ebyte      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    pop        = 1'b1;
                    pend_next  = cmd.flags;
                    pix_next   = cmd.pixel;
                    idx_next   = '0;
                    state_next = first_state(cmd.flags);
                end
            end
            ST_PRE: begin
                case (idx_reg)
                    6'd0:  ebyte = 8'h89;
                    6'd1:  ebyte = 8'h50;
                    6'd2:  ebyte = 8'h4E;
                    6'd3:  ebyte = 8'h47;
                    6'd4:  ebyte = 8'h0D;
                    6'd5:  ebyte = 8'h0A;
                    6'd6:  ebyte = 8'h1A;
                    6'd7:  ebyte = 8'h0A;
                    6'd11: ebyte = 8'd13;
                    6'd12: ebyte = "I";
                    6'd13: ebyte = "H";
                    6'd14: ebyte = "D";
                    6'd15: ebyte = "R";
                    6'd18: ebyte = {1'b0, dims.width[14:8]};
                    6'd19: ebyte = dims.width[7:0];
                    6'd22: ebyte = {1'b0, dims.height[14:8]};
                    6'd23: ebyte = dims.height[7:0];
                    6'd24: ebyte = 8'd8;
                    6'd29: ebyte = crc_out[31:24];
                    6'd30: ebyte = crc_out[23:16];
                    6'd31: ebyte = crc_out[15:8];
                    6'd32: ebyte = crc_out[7:0];
                    6'd33: ebyte = zlen_reg[31:24];
                    6'd34: ebyte = zlen_reg[23:16];
                    6'd35: ebyte = zlen_reg[15:8];
                    6'd36: ebyte = zlen_reg[7:0];
                    6'd37: ebyte = "I";
                    6'd38: ebyte = "D";
                    6'd39: ebyte = "A";
                    6'd40: ebyte = "T";
                    6'd41: ebyte = 8'h78;
                    6'd42: ebyte = 8'h01;
                    default: ebyte = 8'h00;
                endcase
                if (adv) begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    crc_upd  = (idx_reg >= 6'd12 && idx_reg <= 6'd28) || (idx_reg >= 6'd37);
                    crc_rst  = (idx_reg == 6'd11) || (idx_reg == 6'd36);
                    if (idx_reg == 6'd0) begin
                        rawl_next = prod[RAW_W-1:0];
                        alo_next  = 16'd1;
                        ahi_next  = '0;
                        blk_next  = '0;
                    end
                    if (idx_reg == 6'd1) begin
                        zlen_next = 32'(rawl_reg) + 32'(zblocks) * 32'd5 + 32'd6;
                    end
                    if (idx_reg == 6'd42) begin
                        pend_next.pre = 1'b0;
                        idx_next      = '0;
                        e_last        = (pend_next == '0);
                        state_next    = first_state(pend_next);
                    end
                end
            end
            ST_RAW: begin
                ebyte = pend_reg.filt ? 8'h00 : pix_reg;
                if (blk_reg == '0) begin
                    blen_next  = (rawl_reg >= RAW_W'(STORED_BLOCK)) ? 16'(STORED_BLOCK)
                                                                   : rawl_reg[15:0];
                    final_next = rawl_reg <= RAW_W'(STORED_BLOCK);
                    blk_next   = blen_next;
                    idx_next   = '0;
                    state_next = ST_HDR;
                end else if (adv) begin
                    emit      = 1'b1;
                    crc_upd   = 1'b1;
                    alo_next  = lo_n;
                    ahi_next  = hi_n;
                    blk_next  = blk_reg - 16'd1;
                    rawl_next = rawl_reg - RAW_W'(1);
                    if (pend_reg.filt) begin
                        pend_next.filt = 1'b0;
                    end else begin
                        pend_next.pix = 1'b0;
                    end
                    e_last     = (pend_next == '0);
                    idx_next   = '0;
                    state_next = first_state(pend_next);
                end
            end
            ST_HDR: begin
                case (idx_reg)
                    6'd0:    ebyte = {7'd0, final_reg};
                    6'd1:    ebyte = blen_reg[7:0];
                    6'd2:    ebyte = blen_reg[15:8];
                    6'd3:    ebyte = ~blen_reg[7:0];
                    default: ebyte = ~blen_reg[15:8];
                endcase
                if (adv) begin
                    emit     = 1'b1;
                    crc_upd  = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg == 6'd4) begin
                        idx_next   = '0;
                        state_next = ST_RAW;
                    end
                end
            end
            ST_TRAIL: begin
                case (idx_reg)
                    6'd0:  ebyte = ahi_reg[15:8];
                    6'd1:  ebyte = ahi_reg[7:0];
                    6'd2:  ebyte = alo_reg[15:8];
                    6'd3:  ebyte = alo_reg[7:0];
                    6'd4:  ebyte = crc_out[31:24];
                    6'd5:  ebyte = crc_out[23:16];
                    6'd6:  ebyte = crc_out[15:8];
                    6'd7:  ebyte = crc_out[7:0];
                    6'd12: ebyte = "I";
                    6'd13: ebyte = "E";
                    6'd14: ebyte = "N";
                    6'd15: ebyte = "D";
                    6'd16: ebyte = crc_out[31:24];
                    6'd17: ebyte = crc_out[23:16];
                    6'd18: ebyte = crc_out[15:8];
                    6'd19: ebyte = crc_out[7:0];
                    default: ebyte = 8'h00;
                endcase
                if (adv) begin
                    emit     = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    crc_upd  = (idx_reg <= 6'd3) || (idx_reg >= 6'd12 && idx_reg <= 6'd15);
                    crc_rst  = (idx_reg == 6'd7);
                    if (idx_reg == 6'd19) begin
                        pend_next.trail = 1'b0;
                        idx_next        = '0;
                        e_last          = 1'b1;
                        e_end           = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        crc_next = crc_reg;
        if (crc_rst) begin
            crc_next = '1;
        end else if (crc_upd) begin
            crc_next = crc_byte(crc_reg, ebyte);
        end
        mv_next = mv_reg;
        md_next = md_reg;
        ml_next = ml_reg;
        mu_next = mu_reg;
        if (emit) begin
            mv_next = 1'b1;
            md_next = ebyte;
            ml_next = e_last;
            mu_next = e_end;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

    always_ff @(posedge aclk) begin
        md_reg    <= md_next;
        ml_reg    <= ml_next;
        mu_reg    <= mu_next;
        pix_reg   <= pix_next;
        blen_reg  <= blen_next;
        final_reg <= final_next;
        zlen_reg  <= zlen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            pend_reg  <= '0;
            crc_reg   <= '1;
            alo_reg   <= 16'd1;
            ahi_reg   <= '0;
            rawl_reg  <= '0;
            blk_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            pend_reg  <= pend_next;
            crc_reg   <= crc_next;
            alo_reg   <= alo_next;
            ahi_reg   <= ahi_next;
            rawl_reg  <= rawl_next;
            blk_reg   <= blk_next;
            mv_reg    <= mv_next;
        end
    end

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && mu_reg |-> ml_reg)
        else $error("file end without run end");

    a_hdr_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HDR |-> idx_reg <= 6'd4 && blk_reg != '0)
        else $error("block header out of range");

    a_raw_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RAW |-> rawl_reg != '0)
        else $error("raw byte past image end");

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> state_reg == ST_IDLE && pend_reg == '0)
        else $error("command taken while busy");

endmodule

`default_nettype wire

// ===== src/png_gray_stored_encoder.sv =====
// top level: grayscale png encoder with stored deflate blocks
// an accepted pixel is queued as a command; the byte sequencer takes it and sends
// its bytes, row filter bytes, block headers, preamble and trailer one at a time
// through a registered output, holding while m_tready is low; pixels queue ahead
// reset: synchronous active-low aresetn clears counters, queue and sequencer, dims to 1
`default_nettype none

module png_gray_stored_encoder
    import pngenc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic             cfg_addr,
    input  wire logic [DIM_W-1:0] cfg_wdata,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,    // pixel
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,    // out_byte
    output logic                  m_tlast,
    output logic                  m_tuser     // file_end
);

    logic  push, full, pop, not_empty;
    cmd_t  push_cmd, pop_cmd;
    dims_t dims;

    pngenc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_full (full),
        .push      (push),
        .push_cmd  (push_cmd),
        .dims      (dims)
    );

    pngenc_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (not_empty)
    );

    pngenc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dims      (dims),
        .cmd_valid (not_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== bench/tb_png_gray_stored_encoder.sv =====
// self-checking testbench for the grayscale png stored-block encoder
`default_nettype none

module tb_png_gray_stored_encoder;
    import pngenc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BEAT_CAP   = 50;
    localparam int IDLE_LIMIT = 20000;
    localparam int IMG_W      = 24;
    localparam int IMG_H      = 20;
    localparam int EXTRA_PIX  = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       file_end;
    } out_beat_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_addr = REG_WIDTH;
    logic [DIM_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;
    logic             m_tlast;
    logic             m_tuser;

    always #2 aclk = ~aclk;

    png_gray_stored_encoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // encoder state mirror
    logic [DIM_W-1:0] reg_width = DIM_W'(1), reg_height = DIM_W'(1);
    int unsigned      dim_w, dim_h;
    logic [31:0]      idat_crc;
    int unsigned      adler_a, adler_b, col_cnt, blk_left, raw_left;
    bit               file_open, file_done;
    logic [8:0]       byte_fifo[$];
    out_beat_t        expected_beats[$];

    int unsigned errors = 0;
    int unsigned pixels_sent = 0;
    int unsigned beats_seen = 0;
    int unsigned idle_cycles = 0;

    logic [7:0] png_sig[8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    logic [7:0] directed_pixels[20] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55,
        8'hAA, 8'h0F, 8'hF0, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h33, 8'hCC, 8'h01, 8'h02,
        8'h04, 8'h08};

    function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
        logic [31:0] r;
        r = c ^ 32'(b);
        repeat (8) r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'h0);
        return r;
    endfunction

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic void push_byte(logic [7:0] b, bit is_end = 0);
        byte_fifo.push_back({is_end, b});
    endfunction

    function automatic void push_idat(logic [7:0] b);
        idat_crc = crc_next(idat_crc, b);
        push_byte(b);
    endfunction

    function automatic void push_word(logic [31:0] v, bit in_idat);
        for (int i = 3; i >= 0; i--) begin
            if (in_idat) push_idat(v[i*8 +: 8]);
            else push_byte(v[i*8 +: 8]);
        end
    endfunction

    function automatic void put_raw(logic [7:0] b);
        int unsigned  len;
        logic [15:0] l16;
        if (raw_left == 0) return;
        if (blk_left == 0) begin
            len = raw_left < STORED_BLOCK ? raw_left : STORED_BLOCK;
            l16 = len[15:0];
            push_idat(len == raw_left ? 8'h01 : 8'h00);
            push_idat(l16[7:0]);
            push_idat(l16[15:8]);
            push_idat(~l16[7:0]);
            push_idat(~l16[15:8]);
            blk_left = len;
        end
        push_idat(b);
        blk_left--;
        raw_left--;
        adler_a = (adler_a + b) % ADLER_MOD;
        adler_b = (adler_b + adler_a) % ADLER_MOD;
    endfunction

    function automatic void open_file();
        logic [7:0]  ihdr[17];
        logic [31:0] c;
        int unsigned raw, blocks;
        dim_w = clamp_dim(reg_width);
        dim_h = clamp_dim(reg_height);
        ihdr = '{"I", "H", "D", "R", 8'd0, 8'd0, dim_w[15:8], dim_w[7:0], 8'd0, 8'd0,
                 dim_h[15:8], dim_h[7:0], 8'd8, 8'd0, 8'd0, 8'd0, 8'd0};
        foreach (png_sig[i]) push_byte(png_sig[i]);
        push_word(32'd13, 0);
        c = '1;
        foreach (ihdr[i]) begin
            push_byte(ihdr[i]);
            c = crc_next(c, ihdr[i]);
        end
        push_word(~c, 0);
        raw = (dim_w + 1) * dim_h;
        blocks = (raw + STORED_BLOCK - 1) / STORED_BLOCK;
        push_word(2 + raw + 5 * blocks + 4, 0);
        idat_crc = '1;
        push_idat("I"); push_idat("D"); push_idat("A"); push_idat("T");
        push_idat(8'h78); push_idat(8'h01);
        raw_left = raw;
        blk_left = 0;
        adler_a = 1;
        adler_b = 0;
        col_cnt = 0;
        file_open = 1;
    endfunction

    function automatic void close_file();
        logic [7:0]  iend[4];
        logic [31:0] c;
        iend = '{"I", "E", "N", "D"};
        push_word({adler_b[15:0], adler_a[15:0]}, 1);
        push_word(~idat_crc, 0);
        push_word(32'd0, 0);
        c = '1;
        foreach (iend[i]) begin
            push_byte(iend[i]);
            c = crc_next(c, iend[i]);
        end
        c = ~c;
        push_byte(c[31:24]); push_byte(c[23:16]); push_byte(c[15:8]);
        push_byte(c[7:0], 1);
        file_done = 1;
    endfunction

    function automatic void encode_pixel(logic [7:0] px);
        int unsigned n;
        logic [8:0]  e;
        if (!file_done) begin
            if (!file_open) open_file();
            if (col_cnt == 0) put_raw(8'h00);
            put_raw(px);
            col_cnt++;
            if (col_cnt >= dim_w) col_cnt = 0;
            if (raw_left == 0) close_file();
        end
        n = byte_fifo.size() < BEAT_CAP ? byte_fifo.size() : BEAT_CAP;
        for (int k = 0; k < n; k++) begin
            e = byte_fifo.pop_front();
            expected_beats.push_back('{data: e[7:0], last: (k + 1 == n), file_end: e[8]});
        end
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(9) < 6) return 0;
        if ($urandom_range(9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic addr, logic [DIM_W-1:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (!file_open) begin
            if (addr == REG_WIDTH) reg_width = value;
            else reg_height = value;
        end
    endtask

    task automatic send_pixel(logic [7:0] px);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = px;
        do @(posedge aclk); while (!s_tready);
        encode_pixel(px);
        pixels_sent++;
    endtask

    task automatic drain_wait();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // receiver stalls
    int unsigned stall_left = 0;
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(3) == 0) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            out_beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat data=%02h last=%b end=%b",
                         $time, m_tdata, m_tlast, m_tuser);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (want.data !== m_tdata) begin
                    $display("%0t: byte mismatch expected %02h actual %02h",
                             $time, want.data, m_tdata);
                    errors++;
                end
                if (want.last !== m_tlast) begin
                    $display("%0t: tlast mismatch expected %b actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
                if (want.file_end !== m_tuser) begin
                    $display("%0t: file end mismatch expected %b actual %b",
                             $time, want.file_end, m_tuser);
                    errors++;
                end
            end
            // signature is fixed, checked against the literal too
            if (beats_seen < 8 && m_tdata !== png_sig[beats_seen]) begin
                $display("%0t: signature byte %0d expected %02h actual %02h",
                         $time, beats_seen, png_sig[beats_seen], m_tdata);
                errors++;
            end
            beats_seen++;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("png_gray_stored_encoder verification failed");
            $finish;
        end
    end

    initial begin
        int unsigned total;
        total = IMG_W * IMG_H;
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        // walk both registers through their extremes, last setting is the image size
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '0);
        write_reg(REG_WIDTH, '1);
        write_reg(REG_HEIGHT, 15'(MAX_DIM + 1));
        write_reg(REG_WIDTH, DIM_W'(IMG_W));
        write_reg(REG_HEIGHT, DIM_W'(IMG_H));

        foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);

        // pause until idle, then writes that must not disturb the latched size
        drain_wait();
        write_reg(REG_WIDTH, '0);
        write_reg(REG_HEIGHT, '1);

        while (pixels_sent < total) begin
            send_pixel($urandom_range(255));
            if (pixels_sent == total / 2) drain_wait();
        end
        // pixels after the image end are swallowed
        repeat (EXTRA_PIX) send_pixel($urandom_range(255));
        @(negedge aclk);
        s_tvalid = 1'b0;

        while (expected_beats.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("sent %0d pixels of a %0dx%0d image (incl. %0d past the end), %0d beats out",
                 pixels_sent, IMG_W, IMG_H, EXTRA_PIX, beats_seen);
        $display("registers swept through zero, max and out of range values");
        if (errors == 0) begin
            $display("png_gray_stored_encoder verification clean");
        end else begin
            $display("png_gray_stored_encoder verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
